// File: rtl/adjacency_matrix_graph_store_assert.svh
// Assertion macros used by the graph store module.
// Each macro expects clk_i and rst_ni to be visible where it is used.
`ifndef ADJACENCY_MATRIX_GRAPH_STORE_ASSERT_SVH
`define ADJACENCY_MATRIX_GRAPH_STORE_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define AMGS_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define AMGS_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/amgs_pkg.sv
`default_nettype none

package amgs_pkg;

  // Fixed field widths of the command and result transactions.
  localparam int LABEL_W  = 8;
  localparam int WEIGHT_W = 32;
  localparam int GTYPE_W  = 2;
  localparam int FIDX_W   = 5;
  localparam int VCOUNT_W = 6;
  localparam int ARC_W    = 11;

  localparam logic [ARC_W-1:0]    ARC_CAP = 11'd2047;
  localparam logic [WEIGHT_W-1:0] INT_MAX = 32'h7FFF_FFFF;

  // Operation codes.
  typedef enum logic [2:0] {
    KIND_INS_VERTEX = 3'd0,
    KIND_DEL_VERTEX = 3'd1,
    KIND_RENAME     = 3'd2,
    KIND_SET_ARC    = 3'd3,
    KIND_DEL_ARC    = 3'd4,
    KIND_FIRST_NBR  = 3'd5,
    KIND_NEXT_NBR   = 3'd6
  } kind_e;

  // Result status codes.
  typedef enum logic [1:0] {
    STATUS_OK        = 2'd0,
    STATUS_NOT_FOUND = 2'd1,
    STATUS_FULL      = 2'd2,
    STATUS_NO_NBR    = 2'd3
  } status_e;

  typedef struct packed {
    kind_e                      kind;
    logic [LABEL_W-1:0]         vertex_a;
    logic [LABEL_W-1:0]         vertex_b;
    logic [LABEL_W-1:0]         new_label;
    logic signed [WEIGHT_W-1:0] weight;
  } cmd_t;

  typedef struct packed {
    status_e             status;
    logic [FIDX_W-1:0]   found_index;
    logic [VCOUNT_W-1:0] vertex_count;
    logic [ARC_W-1:0]    arc_count;
  } result_t;

endpackage

`default_nettype wire

// File: rtl/adjacency_matrix_graph_store.sv
// Commands are insert, rename, set or delete arc, neighbour search and delete vertex; the arc
// commands also write the mirror cell when undirected. A full insert or an unused kind gives
// its result without walking the memories. One command is in flight at a time: busy stays high
// through the result cycle, so the next command is taken only once the result strobe drops.
// Reset clears the sequencer state, the counts and the graph type, but not the datapath registers.
// The result is shown for one cycle with result_valid_o; the receiver cannot stall it.
`default_nettype none

module adjacency_matrix_graph_store
  import amgs_pkg::*;
#(
  parameter int MAX_VERTICES = 32
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 start,
  input  wire cmd_t                 in_i,
  output logic                      busy,
  output logic                      result_valid_o,
  output result_t                   result_o,
  input  wire logic                 cfg_we_i,
  input  wire logic [GTYPE_W-1:0]   cfg_wdata_i
);

  `include "adjacency_matrix_graph_store_assert.svh"

  localparam int IW  = $clog2(MAX_VERTICES);
  localparam int CW  = $clog2(MAX_VERTICES + 1);
  localparam int MAW = 2 * IW;
  localparam int MDEPTH = 1 << MAW;

  typedef enum logic [10:0] {
    S_IDLE    = 11'b000_0000_0001,
    S_INS     = 11'b000_0000_0010,
    S_LOOK    = 11'b000_0000_0100,
    S_CNT     = 11'b000_0000_1000,
    S_ROW     = 11'b000_0001_0000,
    S_GAP     = 11'b000_0010_0000,
    S_COL     = 11'b000_0100_0000,
    S_ARC_RD  = 11'b000_1000_0000,
    S_ARC_WR  = 11'b001_0000_0000,
    S_ARC_MIR = 11'b010_0000_0000,
    S_NBR     = 11'b100_0000_0000
  } state_e;

  // Result cycle is folded into a separate flag so the state stays a plain sequencer.
  state_e               state_q, state_d;
  logic                 done_q, done_d;
  cmd_t                 op_q, op_d;
  logic [GTYPE_W-1:0]   gtype_q;
  logic [CW-1:0]        n_q, n_d;
  logic [ARC_W-1:0]     arcs_q, arcs_d;
  logic [CW-1:0]        i_q, i_d, j_q, j_d;
  logic                 p_q, p_d;
  logic [IW-1:0]        ka_q, ka_d, kb_q, kb_d;
  logic                 ka_ok_q, ka_ok_d, kb_ok_q, kb_ok_d;
  logic [CW:0]          cnt_q, cnt_d;
  status_e              status_q, status_d;
  logic [IW-1:0]        found_q, found_d;
  logic                 rv_q, rv_d, rcnt_q, rcnt_d;
  logic [IW-1:0]        rtag_q, rtag_d;
  logic                 cw_q, cw_d, lw_q, lw_d;
  logic [MAW-1:0]       cw_addr_q, cw_addr_d;
  logic [IW-1:0]        lw_addr_q, lw_addr_d;

  // Memory ports.
  logic                 m_we, m_re, l_we, l_re;
  logic [MAW-1:0]       m_waddr, m_raddr;
  logic [WEIGHT_W-1:0]  m_wdata, m_rdata;
  logic [IW-1:0]        l_waddr, l_raddr;
  logic [LABEL_W-1:0]   l_wdata, l_rdata;

  logic [WEIGHT_W-1:0]  no_arc, new_val;
  logic [CW-1:0]        ip1, jp1, nm1, nm2;
  logic [ARC_W-1:0]     cnt_ext;
  logic                 need_b;

  function automatic logic [MAW-1:0] cell_addr(input logic [IW-1:0] r, input logic [IW-1:0] c);
    return {r, c};
  endfunction

  amgs_ram #(.WIDTH(WEIGHT_W), .DEPTH(MDEPTH)) u_matrix (
    .clk_i   (clk_i),
    .we_i    (m_we),
    .waddr_i (m_waddr),
    .wdata_i (m_wdata),
    .re_i    (m_re),
    .raddr_i (m_raddr),
    .rdata_o (m_rdata)
  );

  amgs_ram #(.WIDTH(LABEL_W), .DEPTH(MAX_VERTICES)) u_labels (
    .clk_i   (clk_i),
    .we_i    (l_we),
    .waddr_i (l_waddr),
    .wdata_i (l_wdata),
    .re_i    (l_re),
    .raddr_i (l_raddr),
    .rdata_o (l_rdata)
  );

  // Arc encoding for the current graph type.
  assign no_arc  = gtype_q[0] ? INT_MAX : '0;
  assign new_val = (op_q.kind == KIND_DEL_ARC) ? no_arc :
                   (gtype_q[0] ? op_q.weight : WEIGHT_W'(1));
  assign ip1     = i_q + CW'(1);
  assign jp1     = j_q + CW'(1);
  assign nm1     = n_q - CW'(1);
  assign nm2     = n_q - CW'(2);
  assign cnt_ext = ARC_W'(cnt_q);
  assign need_b  = (op_q.kind == KIND_SET_ARC) || (op_q.kind == KIND_DEL_ARC) ||
                   (op_q.kind == KIND_NEXT_NBR);

  // Sequencer: walks the memories for each command.
  always_comb begin
    state_d   = state_q;
    done_d    = 1'b0;
    op_d      = op_q;
    n_d       = n_q;
    arcs_d    = arcs_q;
    i_d       = i_q;
    j_d       = j_q;
    p_d       = p_q;
    ka_d      = ka_q;
    kb_d      = kb_q;
    ka_ok_d   = ka_ok_q;
    kb_ok_d   = kb_ok_q;
    cnt_d     = cnt_q;
    status_d  = status_q;
    found_d   = found_q;
    rv_d      = 1'b0;
    rcnt_d    = 1'b0;
    rtag_d    = rtag_q;
    cw_d      = 1'b0;
    lw_d      = 1'b0;
    cw_addr_d = cw_addr_q;
    lw_addr_d = lw_addr_q;
    m_re      = 1'b0;
    m_raddr   = '0;
    l_re      = 1'b0;
    l_raddr   = '0;
    // Pending copy writes complete in the cycle after their read.
    m_we      = cw_q;
    m_waddr   = cw_addr_q;
    m_wdata   = m_rdata;
    l_we      = lw_q;
    l_waddr   = lw_addr_q;
    l_wdata   = l_rdata;

    unique case (state_q)
      S_IDLE: begin
        if (start && !done_q) begin
          op_d     = in_i;
          status_d = STATUS_OK;
          found_d  = '0;
          i_d      = '0;
          p_d      = 1'b0;
          ka_ok_d  = 1'b0;
          kb_ok_d  = 1'b0;
          unique case (in_i.kind)
            KIND_INS_VERTEX: begin
              if (n_q >= CW'(MAX_VERTICES)) begin
                status_d = STATUS_FULL;
                done_d   = 1'b1;
              end else begin
                l_we    = 1'b1;
                l_waddr = n_q[IW-1:0];
                l_wdata = in_i.vertex_a;
                state_d = S_INS;
              end
            end
            KIND_DEL_VERTEX, KIND_RENAME, KIND_SET_ARC, KIND_DEL_ARC,
            KIND_FIRST_NBR, KIND_NEXT_NBR: begin
              state_d = S_LOOK;
            end
            default: begin
              done_d = 1'b1;
            end
          endcase
        end
      end

      // Clear the new row and column, alternating between the two.
      S_INS: begin
        m_we    = 1'b1;
        m_wdata = no_arc;
        m_waddr = p_q ? cell_addr(n_q[IW-1:0], i_q[IW-1:0])
                      : cell_addr(i_q[IW-1:0], n_q[IW-1:0]);
        p_d = !p_q;
        if (p_q) begin
          if (i_q == n_q) begin
            n_d     = n_q + CW'(1);
            state_d = S_IDLE;
            done_d  = 1'b1;
          end else begin
            i_d = ip1;
          end
        end
      end

      // Scan the labels for both operands; the lowest index wins.
      S_LOOK: begin
        if (i_q < n_q) begin
          l_re    = 1'b1;
          l_raddr = i_q[IW-1:0];
          rv_d    = 1'b1;
          rtag_d  = i_q[IW-1:0];
          i_d     = ip1;
        end
        if (rv_q) begin
          if (!ka_ok_q && (l_rdata == op_q.vertex_a)) begin
            ka_ok_d = 1'b1;
            ka_d    = rtag_q;
          end
          if (!kb_ok_q && (l_rdata == op_q.vertex_b)) begin
            kb_ok_d = 1'b1;
            kb_d    = rtag_q;
          end
        end
        if ((i_q == n_q) && !rv_q) begin
          if (!ka_ok_q || (need_b && !kb_ok_q)) begin
            status_d = STATUS_NOT_FOUND;
            state_d  = S_IDLE;
            done_d   = 1'b1;
          end else begin
            j_d   = '0;
            p_d   = 1'b0;
            cnt_d = '0;
            unique case (op_q.kind)
              KIND_DEL_VERTEX: state_d = S_CNT;
              KIND_RENAME: begin
                l_we    = 1'b1;
                l_waddr = ka_q;
                l_wdata = op_q.new_label;
                state_d = S_IDLE;
                done_d  = 1'b1;
              end
              KIND_SET_ARC, KIND_DEL_ARC: state_d = S_ARC_RD;
              KIND_FIRST_NBR: state_d = S_NBR;
              KIND_NEXT_NBR: begin
                j_d     = CW'(kb_q) + CW'(1);
                state_d = S_NBR;
              end
              default: begin
                state_d = S_IDLE;
                done_d  = 1'b1;
              end
            endcase
          end
        end
      end

      // Count the arcs touching the vertex: its row, and its column when directed.
      S_CNT: begin
        if (j_q < n_q) begin
          m_re    = 1'b1;
          m_raddr = p_q ? cell_addr(j_q[IW-1:0], ka_q) : cell_addr(ka_q, j_q[IW-1:0]);
          rv_d    = 1'b1;
          rcnt_d  = !p_q || (!gtype_q[1] && (j_q[IW-1:0] != ka_q));
          p_d     = !p_q;
          if (p_q) begin
            j_d = jp1;
          end
        end
        if (rv_q && rcnt_q && (m_rdata != no_arc)) begin
          cnt_d = cnt_q + (CW+1)'(1);
        end
        if ((j_q == n_q) && !rv_q) begin
          arcs_d = (arcs_q > cnt_ext) ? arcs_q - cnt_ext : '0;
          if (CW'(ka_q) >= nm1) begin
            n_d     = nm1;
            state_d = S_IDLE;
            done_d  = 1'b1;
          end else begin
            i_d     = CW'(ka_q);
            j_d     = '0;
            state_d = S_ROW;
          end
        end
      end

      // Move every row below the vertex up by one, labels with them.
      S_ROW: begin
        m_re      = 1'b1;
        m_raddr   = cell_addr(ip1[IW-1:0], j_q[IW-1:0]);
        cw_d      = 1'b1;
        cw_addr_d = cell_addr(i_q[IW-1:0], j_q[IW-1:0]);
        if (j_q == '0) begin
          l_re      = 1'b1;
          l_raddr   = ip1[IW-1:0];
          lw_d      = 1'b1;
          lw_addr_d = i_q[IW-1:0];
        end
        if (j_q == nm1) begin
          j_d = '0;
          if (i_q == nm2) begin
            state_d = S_GAP;
          end else begin
            i_d = ip1;
          end
        end else begin
          j_d = jp1;
        end
      end

      // Let the last row copy land before the column pass reads.
      S_GAP: begin
        i_d     = '0;
        j_d     = CW'(ka_q);
        state_d = S_COL;
      end

      // Move every column right of the vertex left by one.
      S_COL: begin
        m_re      = 1'b1;
        m_raddr   = cell_addr(i_q[IW-1:0], jp1[IW-1:0]);
        cw_d      = 1'b1;
        cw_addr_d = cell_addr(i_q[IW-1:0], j_q[IW-1:0]);
        if (j_q == nm2) begin
          j_d = CW'(ka_q);
          if (i_q == nm2) begin
            n_d     = nm1;
            state_d = S_IDLE;
            done_d  = 1'b1;
          end else begin
            i_d = ip1;
          end
        end else begin
          j_d = jp1;
        end
      end

      S_ARC_RD: begin
        m_re    = 1'b1;
        m_raddr = cell_addr(ka_q, kb_q);
        state_d = S_ARC_WR;
      end

      // Read-modify-write of the arc, with the count following the change.
      S_ARC_WR: begin
        if ((m_rdata == no_arc) && (new_val != no_arc)) begin
          if (arcs_q != ARC_CAP) begin
            arcs_d = arcs_q + ARC_W'(1);
          end
        end else if ((m_rdata != no_arc) && (new_val == no_arc)) begin
          if (arcs_q != '0) begin
            arcs_d = arcs_q - ARC_W'(1);
          end
        end
        m_we    = 1'b1;
        m_waddr = cell_addr(ka_q, kb_q);
        m_wdata = new_val;
        if (gtype_q[1]) begin
          state_d = S_ARC_MIR;
        end else begin
          state_d = S_IDLE;
          done_d  = 1'b1;
        end
      end

      S_ARC_MIR: begin
        m_we    = 1'b1;
        m_waddr = cell_addr(kb_q, ka_q);
        m_wdata = new_val;
        state_d = S_IDLE;
        done_d  = 1'b1;
      end

      // Walk the row from the start column to the first present arc, or to the end of the row.
      S_NBR: begin
        if (j_q < n_q) begin
          m_re    = 1'b1;
          m_raddr = cell_addr(ka_q, j_q[IW-1:0]);
          rv_d    = 1'b1;
          rtag_d  = j_q[IW-1:0];
          j_d     = jp1;
        end
        if (rv_q && (m_rdata != no_arc)) begin
          found_d = rtag_q;
          rv_d    = 1'b0;
          state_d = S_IDLE;
          done_d  = 1'b1;
        end else if ((j_q >= n_q) && !rv_q) begin
          status_d = STATUS_NO_NBR;
          state_d  = S_IDLE;
          done_d   = 1'b1;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      done_q  <= 1'b0;
      gtype_q <= '0;
      n_q     <= '0;
      arcs_q  <= '0;
      rv_q    <= 1'b0;
      cw_q    <= 1'b0;
      lw_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
      n_q     <= n_d;
      arcs_q  <= arcs_d;
      rv_q    <= rv_d;
      cw_q    <= cw_d;
      lw_q    <= lw_d;
      if (cfg_we_i) begin
        gtype_q <= cfg_wdata_i;
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    op_q      <= op_d;
    i_q       <= i_d;
    j_q       <= j_d;
    p_q       <= p_d;
    ka_q      <= ka_d;
    kb_q      <= kb_d;
    ka_ok_q   <= ka_ok_d;
    kb_ok_q   <= kb_ok_d;
    cnt_q     <= cnt_d;
    status_q  <= status_d;
    found_q   <= found_d;
    rcnt_q    <= rcnt_d;
    rtag_q    <= rtag_d;
    cw_addr_q <= cw_addr_d;
    lw_addr_q <= lw_addr_d;
  end

  // Result transaction.
  assign busy                  = (state_q != S_IDLE) || done_q;
  assign result_valid_o        = done_q;
  assign result_o.status       = status_q;
  assign result_o.found_index  = FIDX_W'(found_q);
  assign result_o.vertex_count = VCOUNT_W'(n_q);
  assign result_o.arc_count    = arcs_q;

  `AMGS_ASSERT_NXT(a_accept_busy, start && !busy, busy, "accepted command did not raise busy")
  `AMGS_ASSERT_NXT(a_result_ends, done_q, !done_q && (state_q == S_IDLE), "result strobe held")
  `AMGS_ASSERT_IMP(a_found_zero, done_q && (status_q != STATUS_OK), found_q == '0,
                   "neighbour index set on a failed command")
  `AMGS_ASSERT_IMP(a_count_bound, 1'b1, n_q <= CW'(MAX_VERTICES), "vertex count overflow")

endmodule

`default_nettype wire

// File: rtl/amgs_ram.sv
`default_nettype none

// Simple dual-port synchronous memory with a registered read port.
module amgs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // Read port, registered.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

`default_nettype wire
